FILE: src/scl_pkg.sv
package scl_pkg;

    localparam int CNT_W     = 11;
    localparam int NUM_SLOTS = 7;
    localparam int Q_DEPTH   = 2;

    typedef enum logic [1:0] {
        K_WORD = 2'd0,
        K_SEP  = 2'd1,
        K_OP   = 2'd2,
        K_DONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        P_NONE = 2'd0,
        P_LT   = 2'd1,
        P_GT   = 2'd2,
        P_AMP  = 2'd3
    } t_pend;

    localparam logic [7:0] OP_LT   = 8'd0;
    localparam logic [7:0] OP_LTLT = 8'd1;
    localparam logic [7:0] OP_GT   = 8'd2;
    localparam logic [7:0] OP_GTGT = 8'd3;
    localparam logic [7:0] OP_AMP  = 8'd4;
    localparam logic [7:0] OP_AND  = 8'd5;
    localparam logic [7:0] OP_PIPE = 8'd6;

    localparam logic [7:0] CH_NL   = 8'h0a;
    localparam logic [7:0] CH_LT   = 8'h3c;
    localparam logic [7:0] CH_GT   = 8'h3e;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_PIPE = 8'h7c;
    localparam logic [7:0] CH_SP   = 8'h20;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       value;
        logic [CNT_W-1:0] count;
    } t_tok;

    // one accepted character expanded into its ordered result tokens
    typedef struct packed {
        logic [2:0]                num;
        t_tok [NUM_SLOTS-1:0]      toks;
    } t_cmd;

    function automatic logic [7:0] dbl_char(input t_pend p);
        logic [7:0] c;
        c = 8'h00;
        unique case (p)
            P_LT:    c = CH_LT;
            P_GT:    c = CH_GT;
            P_AMP:   c = CH_AMP;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sgl_code(input t_pend p);
        logic [7:0] c;
        c = OP_LT;
        unique case (p)
            P_GT:    c = OP_GT;
            P_AMP:   c = OP_AMP;
            default: c = OP_LT;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] dbl_code(input t_pend p);
        logic [7:0] c;
        c = OP_LTLT;
        unique case (p)
            P_GT:    c = OP_GTGT;
            P_AMP:   c = OP_AND;
            default: c = OP_LTLT;
        endcase
        return c;
    endfunction

    function automatic t_cmd add_tok(input t_cmd cmd, input t_kind kind,
                                     input logic [7:0] value,
                                     input logic [CNT_W-1:0] count);
        t_cmd r;
        r = cmd;
        r.toks[r.num] = '{kind: kind, value: value, count: count};
        r.num = r.num + 3'd1;
        return r;
    endfunction

endpackage

FILE: src/scl_fifo.sv
module scl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

FILE: src/scl_front.sv
module scl_front #(
    parameter int MAX_LINE = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_char_in,
    input  logic          i_line_end,
    output logic          o_wr,
    output scl_pkg::t_cmd o_cmd
);
    import scl_pkg::*;

    localparam int CAP_INT = (MAX_LINE < 2047) ? MAX_LINE : 2047;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

    t_pend            r_pend, n_pend;
    logic             r_psep, n_psep;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cmd             cmd;
    logic             have;
    logic [7:0]       op;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < COUNT_CAP) ? c + 1'b1 : c;
    endfunction

    always_comb begin
        cmd    = '0;
        n_pend = r_pend;
        n_psep = r_psep;
        n_cnt  = r_cnt;
        op     = OP_LT;
        // a newline on the final byte is stripped and never closes an operator
        have   = !(i_line_end && i_char_in == CH_NL);

        if (r_pend != P_NONE) begin
            n_pend = P_NONE;
            if (have && i_char_in == dbl_char(r_pend)) begin
                op   = dbl_code(r_pend);
                have = 1'b0;
            end else begin
                op = sgl_code(r_pend);
            end
            n_cnt = sat_inc(n_cnt);
            if (!n_psep) cmd = add_tok(cmd, K_SEP, 8'h00, n_cnt);
            cmd = add_tok(cmd, K_OP, op, n_cnt);
            cmd = add_tok(cmd, K_SEP, 8'h00, n_cnt);
            n_psep = 1'b1;
        end

        if (have) begin
            case (i_char_in)
                CH_LT:  n_pend = P_LT;
                CH_GT:  n_pend = P_GT;
                CH_AMP: n_pend = P_AMP;
                CH_PIPE: begin
                    n_cnt = sat_inc(n_cnt);
                    if (!n_psep) cmd = add_tok(cmd, K_SEP, 8'h00, n_cnt);
                    cmd = add_tok(cmd, K_OP, OP_PIPE, n_cnt);
                    cmd = add_tok(cmd, K_SEP, 8'h00, n_cnt);
                    n_psep = 1'b1;
                end
                CH_SP: begin
                    if (!n_psep) begin
                        cmd    = add_tok(cmd, K_SEP, 8'h00, n_cnt);
                        n_psep = 1'b1;
                    end
                end
                default: begin
                    if (n_psep) n_cnt = sat_inc(n_cnt);
                    cmd    = add_tok(cmd, K_WORD, i_char_in, n_cnt);
                    n_psep = 1'b0;
                end
            endcase
        end

        if (i_line_end) begin
            if (n_pend != P_NONE) begin
                n_cnt = sat_inc(n_cnt);
                if (!n_psep) cmd = add_tok(cmd, K_SEP, 8'h00, n_cnt);
                cmd = add_tok(cmd, K_OP, sgl_code(n_pend), n_cnt);
                cmd = add_tok(cmd, K_SEP, 8'h00, n_cnt);
            end
            cmd    = add_tok(cmd, K_SEP, 8'h00, n_cnt);
            cmd    = add_tok(cmd, K_DONE, 8'h00, n_cnt);
            n_pend = P_NONE;
            n_psep = 1'b1;
            n_cnt  = '0;
        end
    end

    // characters that only open an operator produce nothing to queue
    assign o_wr  = i_accept && (cmd.num != 3'd0);
    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= P_NONE;
            r_psep <= 1'b1;
            r_cnt  <= '0;
        end else if (i_accept) begin
            r_pend <= n_pend;
            r_psep <= n_psep;
            r_cnt  <= n_cnt;
        end
    end

endmodule

FILE: src/scl_back.sv
module scl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scl_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_rd,
    output logic               o_empty,
    input  logic               i_pop,
    output scl_pkg::t_kind     o_kind,
    output logic [7:0]         o_value,
    output logic [scl_pkg::CNT_W-1:0] o_token_count,
    output logic               o_line_ok,
    output logic               o_last
);
    import scl_pkg::*;

    t_cmd       r_cmd;
    logic [2:0] r_idx;
    logic       r_busy;
    t_tok       cur;
    logic       at_last, fin, load;

    assign cur      = r_cmd.toks[r_idx];
    assign at_last  = (r_idx == r_cmd.num - 3'd1);
    assign fin      = r_busy && i_pop && at_last;
    // refill in the same cycle the final token of a transaction leaves
    assign load     = (!r_busy || fin) && !i_cmd_empty;
    assign o_cmd_rd = load;

    assign o_empty       = !r_busy;
    assign o_kind        = cur.kind;
    assign o_value       = cur.value;
    assign o_token_count = cur.count;
    assign o_line_ok     = (cur.count != '0);
    assign o_last        = (cur.kind == K_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (fin) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_pop) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

FILE: src/shell_command_tokenizer.sv
// Shell command-line tokenizer: one byte per push, line_end on the final byte.
// The front end classifies a character in the cycle it is accepted and turns
// it into a group of 0 to 7 result tokens (word char, separator, operator
// code for < << > >> & && |, and a line-done token carrying the count);
// a two-entry queue of such groups sits between it and the result side.
// Input is taken one byte per cycle while the queue has room; the result
// side hands out one token per cycle while pop is held, and a byte makes
// 0 tokens (one that only opens an operator) up to 7 (at line end), so
// the sustained rate is set by that one-token-per-cycle output.
// token_count saturates at the smaller of MAX_LINE and 2047.
module shell_command_tokenizer #(
    parameter int MAX_LINE = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                i_char_in,
    input  logic                      i_line_end,
    output logic                      empty,
    input  logic                      pop,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_value,
    output logic [scl_pkg::CNT_W-1:0] o_token_count,
    output logic                      o_line_ok,
    output logic                      o_last
);
    import scl_pkg::*;

    localparam int CMD_W = $bits(t_cmd);

    logic   accept;
    logic   q_wr, q_rd, q_full, q_empty;
    t_cmd   f_cmd, q_cmd;
    t_kind  kind;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign o_kind = kind;

    scl_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_char_in  (i_char_in),
        .i_line_end (i_line_end),
        .o_wr       (q_wr),
        .o_cmd      (f_cmd)
    );

    scl_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (f_cmd),
        .i_rd    (q_rd),
        .o_rdata (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    scl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (q_cmd),
        .i_cmd_empty   (q_empty),
        .o_cmd_rd      (q_rd),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_kind        (kind),
        .o_value       (o_value),
        .o_token_count (o_token_count),
        .o_line_ok     (o_line_ok),
        .o_last        (o_last)
    );

endmodule

FILE: tb/shell_command_tokenizer_test.sv
module shell_command_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scl_pkg::*;

    // a small line cap so that random lines reach count saturation
    localparam int LINE_CAP  = 40;
    localparam int COUNT_CAP = (LINE_CAP < 2047) ? LINE_CAP : 2047;

    localparam logic [7:0] SINGLE_OP[4] = '{OP_LT, OP_LT, OP_GT, OP_AMP};
    localparam logic [7:0] DOUBLE_OP[4] = '{OP_LTLT, OP_LTLT, OP_GTGT, OP_AND};
    localparam logic [7:0] DOUBLE_CH[4] = '{8'h00, CH_LT, CH_GT, CH_AMP};

    typedef struct {
        logic [7:0] ch;
        logic       eol;
    } byte_t;

    typedef struct {
        t_kind            kind;
        logic [7:0]       value;
        logic [CNT_W-1:0] count;
        logic             ok;
        logic             last;
    } token_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       i_char_in = 8'h00;
    logic             i_line_end = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic [1:0]       o_kind;
    logic [7:0]       o_value;
    logic [CNT_W-1:0] o_token_count;
    logic             o_line_ok;
    logic             o_last;

    byte_t            bytes_q[$];
    token_t           tokens_due[$];
    int unsigned      errors = 0;
    logic             in_fire = 1'b0;

    // tokenizer state as seen from outside
    t_pend            lex_pend = P_NONE;
    logic             lex_sep = 1'b1;
    logic [CNT_W-1:0] lex_count = '0;

    int unsigned      in_gap = 0;
    int unsigned      out_gap = 0;
    logic             calm = 1'b0;
    int unsigned      calm_left = 0;

    shell_command_tokenizer #(
        .MAX_LINE(LINE_CAP)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_char_in(i_char_in),
        .i_line_end(i_line_end),
        .empty(empty),
        .pop(pop),
        .o_kind(o_kind),
        .o_value(o_value),
        .o_token_count(o_token_count),
        .o_line_ok(o_line_ok),
        .o_last(o_last)
    );

    always #4 i_clk = ~i_clk;

    task automatic report(input string what);
        $display("%0t tokenizer: %s", $realtime, what);
        errors++;
    endtask

    task automatic put_token(input t_kind kind, input logic [7:0] value, input logic last);
        token_t t;
        t.kind  = kind;
        t.value = value;
        t.count = lex_count;
        t.ok    = (lex_count != '0);
        t.last  = last;
        tokens_due.push_back(t);
    endtask

    task automatic put_operator(input logic [7:0] code);
        if (lex_count < COUNT_CAP)
            lex_count++;
        if (!lex_sep)
            put_token(K_SEP, 8'h00, 1'b0);
        put_token(K_OP, code, 1'b0);
        put_token(K_SEP, 8'h00, 1'b0);
        lex_sep = 1'b1;
    endtask

    task automatic lex_char(input logic [7:0] ch, input logic eol);
        logic  have;
        t_pend p;
        have = !(eol && ch == CH_NL);
        p = lex_pend;
        if (p != P_NONE) begin
            lex_pend = P_NONE;
            if (have && ch == DOUBLE_CH[p]) begin
                put_operator(DOUBLE_OP[p]);
                have = 1'b0;
            end else begin
                put_operator(SINGLE_OP[p]);
            end
        end
        if (have) begin
            case (ch)
                CH_LT:   lex_pend = P_LT;
                CH_GT:   lex_pend = P_GT;
                CH_AMP:  lex_pend = P_AMP;
                CH_PIPE: put_operator(OP_PIPE);
                CH_SP: begin
                    if (!lex_sep) begin
                        put_token(K_SEP, 8'h00, 1'b0);
                        lex_sep = 1'b1;
                    end
                end
                default: begin
                    if (lex_sep && lex_count < COUNT_CAP)
                        lex_count++;
                    put_token(K_WORD, ch, 1'b0);
                    lex_sep = 1'b0;
                end
            endcase
        end
        if (eol) begin
            if (lex_pend != P_NONE) begin
                p = lex_pend;
                lex_pend = P_NONE;
                put_operator(SINGLE_OP[p]);
            end
            put_token(K_SEP, 8'h00, 1'b0);
            put_token(K_DONE, 8'h00, 1'b1);
            lex_pend  = P_NONE;
            lex_sep   = 1'b1;
            lex_count = '0;
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_byte(input logic [7:0] ch, input logic eol);
        byte_t b;
        b.ch  = ch;
        b.eol = eol;
        bytes_q.push_back(b);
    endtask

    // monitor: prediction on input transactions, checking on output transactions
    always @(posedge i_clk) begin
        token_t t;
        in_fire = i_rst_n && push && !full;
        if (in_fire)
            lex_char(i_char_in, i_line_end);
        if (i_rst_n && pop && !empty) begin
            if (tokens_due.size() == 0) begin
                report($sformatf("token with none due: kind %0d value %0d", o_kind, o_value));
            end else begin
                t = tokens_due.pop_front();
                if (o_kind != t.kind)
                    report($sformatf("kind %0d, want %0d", o_kind, t.kind));
                if (o_value != t.value)
                    report($sformatf("value %0d, want %0d", o_value, t.value));
                if (o_token_count != t.count)
                    report($sformatf("token_count %0d, want %0d", o_token_count, t.count));
                if (o_line_ok != t.ok)
                    report($sformatf("line_ok %0d, want %0d", o_line_ok, t.ok));
                if (o_last != t.last)
                    report($sformatf("last %0d, want %0d", o_last, t.last));
            end
        end
    end

    // driver: bytes from the queue with random gaps, random pop stalls
    always @(negedge i_clk) begin
        byte_t b;
        if (!i_rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 300);
            end else begin
                calm_left--;
            end
            if (!push || in_fire) begin
                if (in_gap != 0) begin
                    push <= 1'b0;
                    in_gap--;
                end else if (bytes_q.size() != 0) begin
                    b = bytes_q.pop_front();
                    i_char_in  <= b.ch;
                    i_line_end <= b.eol;
                    push       <= 1'b1;
                    in_gap = pick_gap();
                end else begin
                    push <= 1'b0;
                end
            end
            if (out_gap != 0) begin
                pop <= 1'b0;
                out_gap--;
            end else begin
                pop <= 1'b1;
                out_gap = pick_gap();
            end
        end
    end

    initial begin
        int unsigned n_rand;
        int unsigned len;
        int unsigned r;
        logic [7:0]  ch;

        // empty line made only of the trailing newline
        queue_byte(CH_NL, 1'b1);
        // << then a lone > flushed at line end
        queue_byte(CH_LT, 1'b0);
        queue_byte(CH_LT, 1'b0);
        queue_byte(CH_GT, 1'b1);
        // >> then && completed on the final byte
        queue_byte(CH_GT, 1'b0);
        queue_byte(CH_GT, 1'b0);
        queue_byte(CH_AMP, 1'b0);
        queue_byte(CH_AMP, 1'b1);
        // pipe, single <, words around it
        queue_byte(CH_PIPE, 1'b0);
        queue_byte("x", 1'b0);
        queue_byte(CH_LT, 1'b0);
        queue_byte("y", 1'b1);
        // zero byte, inner newline as a word char, & not completed by trailing newline
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hff, 1'b0);
        queue_byte(CH_NL, 1'b0);
        queue_byte(CH_SP, 1'b0);
        queue_byte(CH_AMP, 1'b0);
        queue_byte(CH_NL, 1'b1);
        // > ended by a space on the final byte
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7f, 1'b0);
        queue_byte(CH_GT, 1'b0);
        queue_byte(CH_SP, 1'b1);
        // blank line
        queue_byte(CH_SP, 1'b0);
        queue_byte(CH_SP, 1'b1);

        n_rand = 0;
        while (n_rand < 150) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    ch = 8'h61 + 8'($urandom_range(0, 25));
                else if (r < 45)
                    ch = CH_SP;
                else if (r < 55)
                    ch = CH_LT;
                else if (r < 63)
                    ch = CH_GT;
                else if (r < 71)
                    ch = CH_AMP;
                else if (r < 78)
                    ch = CH_PIPE;
                else if (r < 82)
                    ch = CH_NL;
                else
                    ch = 8'($urandom_range(0, 255));
                // the final byte is often a trailing newline
                if (i == len - 1 && $urandom_range(0, 3) == 0)
                    ch = CH_NL;
                queue_byte(ch, i == len - 1);
            end
            n_rand += len;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (bytes_q.size() != 0 || push || tokens_due.size() != 0);
        repeat (20) @(negedge i_clk);

        if (tokens_due.size() != 0)
            report($sformatf("%0d tokens never arrived", tokens_due.size()));
        if (errors == 0)
            $display("shell_command_tokenizer: match");
        else
            $display("shell_command_tokenizer: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("shell_command_tokenizer: mismatch");
        $finish;
    end

endmodule
